/* rtl/core/bfsp_pkg.sv */
package bfsp_pkg;

  // fixed field widths
  localparam int DIM_W   = 14;
  localparam int STAT_W  = 3;
  localparam int SIDX_W  = 3;
  localparam int CAP_W   = 4;
  localparam int IDLE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 2;

  // request kinds
  localparam logic KIND_TAKE  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] REG_MAX_WIDTH  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_MAX_HEIGHT = 2'd1;
  localparam logic [CFGI_W-1:0] REG_SLOT_CAP   = 2'd2;
  localparam logic [CFGI_W-1:0] REG_IDLE_LIMIT = 2'd3;

  // register reset values
  localparam logic [DIM_W-1:0]  MAX_DIM_RST    = 14'd4096;
  localparam logic [CAP_W-1:0]  SLOT_CAP_RST   = 4'd8;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd600;
  localparam logic [IDLE_W-1:0] IDLE_SAT       = 16'hFFFF;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_REUSED  = 3'd0,
    ST_NEW     = 3'd1,
    ST_EVICTED = 3'd2,
    ST_REFUSED = 3'd3,
    ST_FRAME   = 3'd4
  } bfsp_status_t;

  // operations broadcast to the slot cells
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TAKE,
    CMD_PUT,
    CMD_FREE,
    CMD_CLEAR
  } bfsp_op_t;

  typedef struct packed {
    bfsp_op_t op;
    logic     evict;
  } bfsp_cmd_t;

  // flags of the search token walking the cell chain
  typedef struct packed {
    logic fit_ok;
    logic ev_ok;
  } bfsp_flags_t;

endpackage

/* rtl/core/best_fit_slot_pool_core.sv */
// Best-fit pool of image slots.
// Input channel (in_valid / in_stall) carries one request: kind 0 asks for
// a req_width x req_height slot, kind 1 marks the end of a frame with
// frame_used set when any take happened during it. Each request produces
// exactly one result on the output channel (out_valid / out_stall): status,
// slot_index, slot_width, slot_height and trimmed.
// A search token walks the chain of SLOTS slot cells, one cell per cycle,
// collecting the smallest fitting idle slot, the largest idle slot and the
// held count; a new slot's rounded size is computed alongside it.
// One request is in flight at a time: a new request is accepted only once
// the previous one's result has moved into the output register, the chain
// walk being the dominant part of the wait.
// The result sits in an output register: while out_stall holds it, the
// next request is still accepted and worked on, and its result waits
// until the register frees up.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// while idle only; the block does not enforce it.
// Reset empties the pool, clears the idle frame count and loads register
// defaults: maxima 4096, cap 8, idle limit 600.
module best_fit_slot_pool_core #(
  parameter int SLOTS           = 8,
  parameter int BYTES_PER_PIXEL = 4,
  parameter int GRAIN           = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [bfsp_pkg::CFGI_W-1:0] cfg_index,
  input  logic [bfsp_pkg::CFG_W-1:0]  cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [bfsp_pkg::DIM_W-1:0]  req_width,
  input  logic [bfsp_pkg::DIM_W-1:0]  req_height,
  input  logic                        frame_used,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfsp_pkg::STAT_W-1:0] status,
  output logic [bfsp_pkg::SIDX_W-1:0] slot_index,
  output logic [bfsp_pkg::DIM_W-1:0]  slot_width,
  output logic [bfsp_pkg::DIM_W-1:0]  slot_height,
  output logic                        trimmed
);
  import bfsp_pkg::*;

  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int BYTES_W  = 2 * DIM_W + $clog2(BYTES_PER_PIXEL);
  localparam int AREA_W   = 2 * DIM_W;
  localparam int SCAN_CYC = (SLOTS > 5) ? SLOTS : 5;
  localparam int SCNT_W   = $clog2(SCAN_CYC + 1);
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_OUT
  } state_t;

  // configuration registers
  logic [DIM_W-1:0]  width_lim;
  logic [DIM_W-1:0]  height_lim;
  logic [CAP_W-1:0]  slot_cap;
  logic [IDLE_W-1:0] idle_limit;

  // control state
  state_t            state;
  logic [SCNT_W-1:0] scan_cnt;
  logic [IDLE_W-1:0] idle_count;
  logic [IDLE_W-1:0] idle_count_next;

  // captured request
  logic              req_kind;
  logic [DIM_W-1:0]  req_w;
  logic [DIM_W-1:0]  req_h;
  logic              req_turned;

  // pending result
  bfsp_status_t      res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [DIM_W-1:0]  res_w;
  logic [DIM_W-1:0]  res_h;
  logic              res_trim;
  bfsp_status_t      res_status_next;
  logic [IDX_W-1:0]  res_idx_next;
  logic [DIM_W-1:0]  res_w_next;
  logic [DIM_W-1:0]  res_h_next;
  logic              res_trim_next;

  // new slot size
  logic [DIM_W-1:0]   new_w;
  logic [DIM_W-1:0]   new_h;
  logic [AREA_W-1:0]  new_area;
  logic [BYTES_W-1:0] new_bytes;

  // cell chain
  bfsp_cmd_t        cmd;
  bfsp_cmd_t        cmd_go;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] ev_sel;

  logic [CNT_W-1:0]   tk_cnt       [SLOTS+1];
  bfsp_flags_t        tk_flags     [SLOTS+1];
  logic [IDX_W-1:0]   tk_fit_idx   [SLOTS+1];
  logic [BYTES_W-1:0] tk_fit_bytes [SLOTS+1];
  logic [DIM_W-1:0]   tk_fit_w     [SLOTS+1];
  logic [DIM_W-1:0]   tk_fit_h     [SLOTS+1];
  logic [IDX_W-1:0]   tk_ev_idx    [SLOTS+1];
  logic [BYTES_W-1:0] tk_ev_bytes  [SLOTS+1];

  logic [DIM_W-1:0]   c_w     [SLOTS+1];
  logic [DIM_W-1:0]   c_h     [SLOTS+1];
  logic [BYTES_W-1:0] c_bytes [SLOTS+1];
  logic               c_taken [SLOTS+1];
  logic [SLOTS-1:0]   cell_valid;
  logic [SLOTS-1:0]   cell_taken;

  logic               in_accept;
  logic               out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= MAX_DIM_RST;
      height_lim <= MAX_DIM_RST;
      slot_cap   <= SLOT_CAP_RST;
      idle_limit <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_WIDTH:  width_lim  <= cfg_data[DIM_W-1:0];
        REG_MAX_HEIGHT: height_lim <= cfg_data[DIM_W-1:0];
        REG_SLOT_CAP:   slot_cap   <= cfg_data[CAP_W-1:0];
        REG_IDLE_LIMIT: idle_limit <= cfg_data[IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // rounding of the requested dimensions
  bfsp_round #(.GRAIN(GRAIN)) u_round_w (
    .clk     (clk),
    .value   (req_w),
    .limit   (width_lim),
    .rounded (new_w)
  );

  bfsp_round #(.GRAIN(GRAIN)) u_round_h (
    .clk     (clk),
    .value   (req_h),
    .limit   (height_lim),
    .rounded (new_h)
  );

  // byte size of the new slot
  always_ff @(posedge clk) begin
    new_area  <= AREA_W'(new_w) * AREA_W'(new_h);
    new_bytes <= BYTES_W'(BYTES_W'(new_area) * BYTES_W'(BYTES_PER_PIXEL));
  end

  // empty token into the head of the chain, nothing beyond the tail
  assign tk_cnt[0]       = '0;
  assign tk_flags[0]     = '0;
  assign tk_fit_idx[0]   = '0;
  assign tk_fit_bytes[0] = '0;
  assign tk_fit_w[0]     = '0;
  assign tk_fit_h[0]     = '0;
  assign tk_ev_idx[0]    = '0;
  assign tk_ev_bytes[0]  = '0;
  assign c_w[SLOTS]      = '0;
  assign c_h[SLOTS]      = '0;
  assign c_bytes[SLOTS]  = '0;
  assign c_taken[SLOTS]  = 1'b0;

  assign cmd_go = (state == S_DECIDE) ? cmd : bfsp_cmd_t'{op: CMD_NONE, evict: 1'b0};

  // slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bfsp_cell #(
      .IDX     (i),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .BYTES_W (BYTES_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .req_w         (req_w),
      .req_h         (req_h),
      .cmd           (cmd_go),
      .sel_idx       (sel_idx),
      .ev_idx        (ev_sel),
      .new_w         (new_w),
      .new_h         (new_h),
      .new_bytes     (new_bytes),
      .in_cnt        (tk_cnt[i]),
      .in_flags      (tk_flags[i]),
      .in_fit_idx    (tk_fit_idx[i]),
      .in_fit_bytes  (tk_fit_bytes[i]),
      .in_fit_w      (tk_fit_w[i]),
      .in_fit_h      (tk_fit_h[i]),
      .in_ev_idx     (tk_ev_idx[i]),
      .in_ev_bytes   (tk_ev_bytes[i]),
      .out_cnt       (tk_cnt[i+1]),
      .out_flags     (tk_flags[i+1]),
      .out_fit_idx   (tk_fit_idx[i+1]),
      .out_fit_bytes (tk_fit_bytes[i+1]),
      .out_fit_w     (tk_fit_w[i+1]),
      .out_fit_h     (tk_fit_h[i+1]),
      .out_ev_idx    (tk_ev_idx[i+1]),
      .out_ev_bytes  (tk_ev_bytes[i+1]),
      .nb_w          (c_w[i+1]),
      .nb_h          (c_h[i+1]),
      .nb_bytes      (c_bytes[i+1]),
      .nb_taken      (c_taken[i+1]),
      .valid         (cell_valid[i]),
      .taken         (c_taken[i]),
      .ent_w         (c_w[i]),
      .ent_h         (c_h[i]),
      .ent_bytes     (c_bytes[i])
    );
    assign cell_taken[i] = c_taken[i];
  end

  // decision once the token has left the tail of the chain
  always_comb begin
    logic [CNT_W-1:0]  n;
    logic              bad;
    logic              full;
    logic [IDLE_W-1:0] idle_inc;

    n        = tk_cnt[SLOTS];
    bad      = (req_w == '0) || (req_h == '0) || (req_w > width_lim) ||
               (req_h > height_lim);
    full     = (n >= CNT_W'(SLOTS)) || (CMP_W'(n) >= CMP_W'(slot_cap));
    idle_inc = (idle_count == IDLE_SAT) ? idle_count : idle_count + 1'b1;

    cmd             = '{op: CMD_NONE, evict: 1'b0};
    sel_idx         = '0;
    ev_sel          = tk_ev_idx[SLOTS];
    res_status_next = ST_REFUSED;
    res_idx_next    = '0;
    res_w_next      = '0;
    res_h_next      = '0;
    res_trim_next   = 1'b0;
    idle_count_next = idle_count;

    if (req_kind == KIND_TAKE) begin
      if (!bad) begin
        if (tk_flags[SLOTS].fit_ok) begin
          cmd             = '{op: CMD_TAKE, evict: 1'b0};
          sel_idx         = tk_fit_idx[SLOTS];
          res_status_next = ST_REUSED;
          res_idx_next    = tk_fit_idx[SLOTS];
          res_w_next      = tk_fit_w[SLOTS];
          res_h_next      = tk_fit_h[SLOTS];
        end else if (full) begin
          // evict the largest idle slot, new one goes to the end
          if (tk_flags[SLOTS].ev_ok) begin
            cmd             = '{op: CMD_PUT, evict: 1'b1};
            sel_idx         = IDX_W'(n - 1'b1);
            res_status_next = ST_EVICTED;
            res_idx_next    = IDX_W'(n - 1'b1);
            res_w_next      = new_w;
            res_h_next      = new_h;
          end
        end else begin
          cmd             = '{op: CMD_PUT, evict: 1'b0};
          sel_idx         = IDX_W'(n);
          res_status_next = ST_NEW;
          res_idx_next    = IDX_W'(n);
          res_w_next      = new_w;
          res_h_next      = new_h;
        end
      end
    end else begin
      // end of frame: release every slot, track idle frames
      res_status_next = ST_FRAME;
      cmd             = '{op: CMD_FREE, evict: 1'b0};
      if (req_turned) begin
        idle_count_next = '0;
      end else if (n != '0) begin
        if (idle_inc >= idle_limit) begin
          cmd             = '{op: CMD_CLEAR, evict: 1'b0};
          idle_count_next = '0;
          res_trim_next   = 1'b1;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_cnt   <= '0;
      idle_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // result taken downstream; the output step refills it itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_kind   <= kind;
            req_w      <= req_width;
            req_h      <= req_height;
            req_turned <= frame_used;
            scan_cnt   <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt == SCNT_W'(SCAN_CYC - 1)) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_DECIDE: begin
          res_status <= res_status_next;
          res_idx    <= res_idx_next;
          res_w      <= res_w_next;
          res_h      <= res_h_next;
          res_trim   <= res_trim_next;
          idle_count <= idle_count_next;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            slot_index  <= SIDX_W'(res_idx);
            slot_width  <= res_w;
            slot_height <= res_h;
            trimmed     <= res_trim;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // held slots always form a prefix of the table
  assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, cell_valid} + (SLOTS + 1)'(1)))
    else $error("held slots do not form a prefix");

  // only held slots can be taken
  assert property (@(posedge clk) disable iff (rst)
    (cell_taken & ~cell_valid) == '0)
    else $error("slot taken without being held");

  // a reused slot lies within the held part of the table
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) && tk_flags[SLOTS].fit_ok |-> CNT_W'(tk_fit_idx[SLOTS]) < tk_cnt[SLOTS])
    else $error("best fit points past the held slots");

  // a result only appears from the output step of the sequencer
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  // trimming is only reported for an end of frame
  assert property (@(posedge clk) disable iff (rst)
    out_valid && trimmed |-> status == ST_FRAME)
    else $error("trim reported on a take result");

endmodule

/* rtl/core/bfsp_round.sv */
module bfsp_round #(
  parameter int GRAIN = 256
) (
  input  logic                       clk,
  input  logic [bfsp_pkg::DIM_W-1:0] value,
  input  logic [bfsp_pkg::DIM_W-1:0] limit,
  output logic [bfsp_pkg::DIM_W-1:0] rounded
);
  import bfsp_pkg::*;

  localparam int SUM_W   = DIM_W + 1;
  localparam int GR_W    = $clog2(GRAIN);
  localparam int SH      = SUM_W + GR_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << SH) / GRAIN);
  localparam logic [SUM_W-1:0]   GRAIN_V = SUM_W'(GRAIN);
  localparam logic [SUM_W-1:0]   ADD_V   = SUM_W'(GRAIN - 1);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum_d1;
  logic [SUM_W-1:0]  sum_d2;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  diff;
  logic [SUM_W-1:0]  fin;

  // value plus grain minus one, to be floored to a grain multiple
  assign sum = SUM_W'(value) + ADD_V;

  // quotient estimate is exact or one short, fixed by a single compare
  assign diff = sum_d2 - base;
  assign fin  = (diff >= GRAIN_V) ? base + GRAIN_V : base;

  // reciprocal multiply, back to a grain multiple, correct and clamp
  always_ff @(posedge clk) begin
    prod    <= PROD_W'(sum) * PROD_W'(RECIP);
    sum_d1  <= sum;
    base    <= SUM_W'(SUM_W'(prod >> SH) * GRAIN_V);
    sum_d2  <= sum_d1;
    rounded <= (fin < SUM_W'(limit)) ? DIM_W'(fin) : limit;
  end

endmodule

/* rtl/core/bfsp_cell.sv */
module bfsp_cell #(
  parameter int IDX     = 0,
  parameter int IDX_W   = 3,
  parameter int CNT_W   = 4,
  parameter int BYTES_W = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  // broadcast request and command
  input  logic [bfsp_pkg::DIM_W-1:0] req_w,
  input  logic [bfsp_pkg::DIM_W-1:0] req_h,
  input  bfsp_pkg::bfsp_cmd_t        cmd,
  input  logic [IDX_W-1:0]           sel_idx,
  input  logic [IDX_W-1:0]           ev_idx,
  input  logic [bfsp_pkg::DIM_W-1:0] new_w,
  input  logic [bfsp_pkg::DIM_W-1:0] new_h,
  input  logic [BYTES_W-1:0]         new_bytes,
  // search token from the left neighbour
  input  logic [CNT_W-1:0]           in_cnt,
  input  bfsp_pkg::bfsp_flags_t      in_flags,
  input  logic [IDX_W-1:0]           in_fit_idx,
  input  logic [BYTES_W-1:0]         in_fit_bytes,
  input  logic [bfsp_pkg::DIM_W-1:0] in_fit_w,
  input  logic [bfsp_pkg::DIM_W-1:0] in_fit_h,
  input  logic [IDX_W-1:0]           in_ev_idx,
  input  logic [BYTES_W-1:0]         in_ev_bytes,
  // search token to the right neighbour
  output logic [CNT_W-1:0]           out_cnt,
  output bfsp_pkg::bfsp_flags_t      out_flags,
  output logic [IDX_W-1:0]           out_fit_idx,
  output logic [BYTES_W-1:0]         out_fit_bytes,
  output logic [bfsp_pkg::DIM_W-1:0] out_fit_w,
  output logic [bfsp_pkg::DIM_W-1:0] out_fit_h,
  output logic [IDX_W-1:0]           out_ev_idx,
  output logic [BYTES_W-1:0]         out_ev_bytes,
  // right neighbour's entry, pulled in when a slot is removed
  input  logic [bfsp_pkg::DIM_W-1:0] nb_w,
  input  logic [bfsp_pkg::DIM_W-1:0] nb_h,
  input  logic [BYTES_W-1:0]         nb_bytes,
  input  logic                       nb_taken,
  // this entry
  output logic                       valid,
  output logic                       taken,
  output logic [bfsp_pkg::DIM_W-1:0] ent_w,
  output logic [bfsp_pkg::DIM_W-1:0] ent_h,
  output logic [BYTES_W-1:0]         ent_bytes
);
  import bfsp_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic idle_slot;
  logic fits;
  logic better_fit;
  logic better_ev;
  logic shift_in;

  // best fit wants the smallest, eviction the largest; ties keep the earlier slot
  assign idle_slot  = valid && !taken;
  assign fits       = idle_slot && (ent_w >= req_w) && (ent_h >= req_h);
  assign better_fit = fits && (!in_flags.fit_ok || (ent_bytes < in_fit_bytes));
  assign better_ev  = idle_slot && (!in_flags.ev_ok || (ent_bytes > in_ev_bytes));
  assign shift_in   = cmd.evict && (MY_IDX >= ev_idx) && (MY_IDX < sel_idx);

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt   <= '0;
      out_flags <= '0;
    end else begin
      out_cnt          <= in_cnt + CNT_W'(valid);
      out_flags.fit_ok <= in_flags.fit_ok || better_fit;
      out_flags.ev_ok  <= in_flags.ev_ok || better_ev;
    end
  end

  always_ff @(posedge clk) begin
    out_fit_idx   <= better_fit ? MY_IDX : in_fit_idx;
    out_fit_bytes <= better_fit ? ent_bytes : in_fit_bytes;
    out_fit_w     <= better_fit ? ent_w : in_fit_w;
    out_fit_h     <= better_fit ? ent_h : in_fit_h;
    out_ev_idx    <= better_ev ? MY_IDX : in_ev_idx;
    out_ev_bytes  <= better_ev ? ent_bytes : in_ev_bytes;
  end

  // entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      taken <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_FREE: begin
          taken <= 1'b0;
        end
        CMD_CLEAR: begin
          valid <= 1'b0;
          taken <= 1'b0;
        end
        CMD_TAKE: begin
          if (MY_IDX == sel_idx) begin
            taken <= 1'b1;
          end
        end
        CMD_PUT: begin
          if (MY_IDX == sel_idx) begin
            valid <= 1'b1;
            taken <= 1'b1;
          end else if (shift_in) begin
            taken <= nb_taken;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry payload: new slot or shift down from the right
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_PUT) begin
      if (MY_IDX == sel_idx) begin
        ent_w     <= new_w;
        ent_h     <= new_h;
        ent_bytes <= new_bytes;
      end else if (shift_in) begin
        ent_w     <= nb_w;
        ent_h     <= nb_h;
        ent_bytes <= nb_bytes;
      end
    end
  end

endmodule
